// ----- design/imnpf_pkg.sv -----
package imnpf_pkg;

    localparam int unsigned STATE_W  = 64;
    localparam int unsigned COL_W    = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned N_COLS   = STATE_W / COL_W;

    // High nibble of every byte
    localparam logic [STATE_W-1:0] HIGH_NIB_MASK = 64'hF0F0_F0F0_F0F0_F0F0;
    localparam logic [BYTE_W-1:0]  GF_POLY_LO    = 8'h1B;

    typedef struct packed {
        logic [STATE_W-1:0] first_ciphertext;
        logic [STATE_W-1:0] second_ciphertext;
    } t_pair_in;

    typedef struct packed {
        logic [STATE_W-1:0] difference;
        logic               pathway_ok;
    } t_pair_out;

    function automatic logic [BYTE_W-1:0] xtime8(input logic [BYTE_W-1:0] v);
        xtime8 = {v[BYTE_W-2:0], 1'b0} ^ (v[BYTE_W-1] ? GF_POLY_LO : '0);
    endfunction

    // GF(2^8) product with a 4-bit constant
    function automatic logic [BYTE_W-1:0] gmul(input logic [BYTE_W-1:0] a,
                                               input logic [3:0]        k);
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] p;
        acc = '0;
        p   = a;
        for (int b = 0; b < 4; b++) begin
            if (k[b]) acc = acc ^ p;
            p = xtime8(p);
        end
        gmul = acc;
    endfunction

endpackage

// ----- design/imnpf_col_lane.sv -----
module imnpf_col_lane (
    input  logic                        i_clk,
    input  logic [imnpf_pkg::COL_W-1:0] i_col,
    output logic [imnpf_pkg::COL_W-1:0] o_col
);
    import imnpf_pkg::*;

    logic [BYTE_W-1:0] a0, a1, a2, a3;
    logic [COL_W-1:0]  n_col;
    logic [COL_W-1:0]  r_col;

    assign {a0, a1, a2, a3} = i_col;

    // inverse MixColumns, circulant row (14, 11, 13, 9)
    always_comb begin
        n_col[31:24] = gmul(a0, 4'd14) ^ gmul(a1, 4'd11) ^ gmul(a2, 4'd13) ^ gmul(a3, 4'd9);
        n_col[23:16] = gmul(a0, 4'd9)  ^ gmul(a1, 4'd14) ^ gmul(a2, 4'd11) ^ gmul(a3, 4'd13);
        n_col[15:8]  = gmul(a0, 4'd13) ^ gmul(a1, 4'd9)  ^ gmul(a2, 4'd14) ^ gmul(a3, 4'd11);
        n_col[7:0]   = gmul(a0, 4'd11) ^ gmul(a1, 4'd13) ^ gmul(a2, 4'd9)  ^ gmul(a3, 4'd14);
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
    end

    assign o_col = r_col;

endmodule

// ----- design/imnpf_merge.sv -----
module imnpf_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [imnpf_pkg::STATE_W-1:0] i_first,
    input  logic [imnpf_pkg::STATE_W-1:0] i_second,
    output logic                          o_valid,
    output imnpf_pkg::t_pair_out          o_result
);
    import imnpf_pkg::*;

    logic [STATE_W-1:0] n_diff;
    t_pair_out          r_result;
    logic               r_valid;

    assign n_diff = i_first ^ i_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_result.difference <= n_diff;
        r_result.pathway_ok <= ((n_diff & HIGH_NIB_MASK) == '0);
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- design/inverse_mix_nibbles_pair_filter_top.sv -----
// Channel  | Direction | Handshake              | Word
// ---------+-----------+------------------------+---------------------------------
// pair in  | in        | start & !busy          | i_pair   (t_pair_in, 2 x 64 bit)
// result   | out       | o_valid, one-cycle     | o_result (t_pair_out, 64 + 1 bit)
//
// One word per cycle. An accepted word passes two register stages, column
// lanes then the merge, before it shows on o_result.
// busy is always low: the datapath is a fixed pipeline with no loop.
// Synchronous active-low reset clears the valid pipeline only.
// The receiver cannot stall; every result is shown for exactly one cycle.
module inverse_mix_nibbles_pair_filter_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  imnpf_pkg::t_pair_in   i_pair,
    output logic                  o_valid,
    output imnpf_pkg::t_pair_out  o_result
);
    import imnpf_pkg::*;

    logic [STATE_W-1:0] lane_first;
    logic [STATE_W-1:0] lane_second;
    logic               r_s1_valid;
    logic               accept;

    // No back-pressure anywhere, so the block never refuses a word.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Four lanes: each state split into its two columns, each column unmixed
    // on its own copy of the inverse MixColumns network.
    for (genvar c = 0; c < N_COLS; c++) begin : g_col
        imnpf_col_lane u_lane_first (
            .i_clk (i_clk),
            .i_col (i_pair.first_ciphertext[c*COL_W +: COL_W]),
            .o_col (lane_first[c*COL_W +: COL_W])
        );
        imnpf_col_lane u_lane_second (
            .i_clk (i_clk),
            .i_col (i_pair.second_ciphertext[c*COL_W +: COL_W]),
            .o_col (lane_second[c*COL_W +: COL_W])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    // Merge: XOR the unmixed states and test the high nibbles.
    imnpf_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .i_first  (lane_first),
        .i_second (lane_second),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // A result strobe follows each accepted word through the lane and merge registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_rst_n, 2)) |-> (o_valid == $past(accept, 2)))
        else $error("result strobe out of step with accepted words");

    // Flag agrees with the difference it travels with.
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.pathway_ok ==
                     ((o_result.difference & HIGH_NIB_MASK) == '0)))
        else $error("pathway flag disagrees with difference");

    // Merged difference is the XOR of the lane outputs of the previous cycle.
    a_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.difference == $past(lane_first ^ lane_second)))
        else $error("difference does not match lane outputs");

endmodule

// ----- bench/tb_inverse_mix_nibbles_pair_filter_top.sv -----
module tb_inverse_mix_nibbles_pair_filter_top;

    import imnpf_pkg::*;

    // Clock, reset and block ports. Every input holds a known value from time 0.
    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_pair_in  i_pair  = '0;
    logic      o_valid;
    t_pair_out o_result;

    // Words waiting to go in, and the results they should produce, oldest first.
    t_pair_in  pair_backlog[$];
    t_pair_out expected_results[$];

    int unsigned words_sent     = 0;
    int unsigned mismatch_count = 0;

    inverse_mix_nibbles_pair_filter_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_pair   (i_pair),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // 20-unit period: low half, then high half.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // GF(2^8) arithmetic, polynomial 0x11B
    // ------------------------------------------------------------------

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY_LO : 8'h00);
    endfunction

    // Inverse column mix, built from doublings:
    //   9 = 8+1, 11 = 8+2+1, 13 = 8+4+1, 14 = 8+4+2
    function automatic logic [31:0] unmix_column(input logic [31:0] col);
        logic [7:0] a   [4];
        logic [7:0] x2  [4];
        logic [7:0] x4  [4];
        logic [7:0] x8  [4];
        logic [7:0] m9  [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [31:0] res;
        for (int i = 0; i < 4; i++) begin
            a[i]   = col[31-8*i -: 8];
            x2[i]  = gf_double(a[i]);
            x4[i]  = gf_double(x2[i]);
            x8[i]  = gf_double(x4[i]);
            m9[i]  = x8[i] ^ a[i];
            m11[i] = x8[i] ^ x2[i] ^ a[i];
            m13[i] = x8[i] ^ x4[i] ^ a[i];
            m14[i] = x8[i] ^ x4[i] ^ x2[i];
        end
        // circulant rows: byte i takes 14, 11, 13, 9 starting at its own position
        for (int i = 0; i < 4; i++)
            res[31-8*i -: 8] = m14[i] ^ m11[(i+1)%4] ^ m13[(i+2)%4] ^ m9[(i+3)%4];
        return res;
    endfunction

    // Forward column mix (2, 3, 1, 1); only used to build pairs whose
    // difference lands where we want it, since the inverse mix is linear.
    function automatic logic [31:0] mix_column(input logic [31:0] col);
        logic [7:0] a [4];
        logic [31:0] res;
        for (int i = 0; i < 4; i++)
            a[i] = col[31-8*i -: 8];
        for (int i = 0; i < 4; i++)
            res[31-8*i -: 8] = gf_double(a[i]) ^ gf_double(a[(i+1)%4]) ^ a[(i+1)%4]
                               ^ a[(i+2)%4] ^ a[(i+3)%4];
        return res;
    endfunction

    function automatic logic [63:0] unmix_state(input logic [63:0] s);
        return {unmix_column(s[63:32]), unmix_column(s[31:0])};
    endfunction

    function automatic logic [63:0] mix_state(input logic [63:0] s);
        return {mix_column(s[63:32]), mix_column(s[31:0])};
    endfunction

    // What the filter should say about one pair.
    function automatic t_pair_out filter_verdict(input t_pair_in pair);
        t_pair_out r;
        r.difference = unmix_state(pair.first_ciphertext)
                       ^ unmix_state(pair.second_ciphertext);
        r.pathway_ok = ((r.difference & HIGH_NIB_MASK) == '0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [63:0] random_state();
        return {$urandom(), $urandom()};
    endfunction

    // Queue a pair whose inverse-mixed difference is exactly diff.
    task automatic queue_with_difference(input logic [63:0] first, input logic [63:0] diff);
        t_pair_in p;
        p.first_ciphertext  = first;
        p.second_ciphertext = first ^ mix_state(diff);
        pair_backlog.push_back(p);
    endtask

    task automatic queue_pair(input logic [63:0] first, input logic [63:0] second);
        t_pair_in p;
        p.first_ciphertext  = first;
        p.second_ciphertext = second;
        pair_backlog.push_back(p);
    endtask

    task automatic note_mismatch(input string what, input t_pair_out want,
                                 input t_pair_out got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %0d at %0t: %s; expected diff=%h ok=%b, got diff=%h ok=%b",
                     mismatch_count, $realtime, what, want.difference, want.pathway_ok,
                     got.difference, got.pathway_ok);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents the backlog one word at a time. A word is taken at an
    // edge where start is high and busy is low; start stays high across
    // back-to-back words. Idles about a third of the time, except for a
    // stretch in the middle of the run where it pushes a word every cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_pairs
        logic slot_free;
        logic hold_off;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            slot_free = !start || !busy;
            if (start && !busy)
                words_sent++;
            if (slot_free) begin
                hold_off = (words_sent < 300 || words_sent > 500)
                           && ($urandom_range(99, 0) < 34);
                if (pair_backlog.size() != 0 && !hold_off) begin
                    start  <= 1'b1;
                    i_pair <= pair_backlog.pop_front();
                end else begin
                    start  <= 1'b0;
                    i_pair <= {random_state(), random_state()};  // junk while idle
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: a result is live for one cycle only and is taken at the edge
    // closing that cycle. The result check runs before the new expectation
    // is queued, so a stray result cannot match the word accepted alongside.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_results
        t_pair_out want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("result with nothing outstanding", '0, o_result);
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.difference !== want.difference)
                        note_mismatch("difference", want, o_result);
                    if (o_result.pathway_ok !== want.pathway_ok)
                        note_mismatch("pathway_ok", want, o_result);
                end
            end
            if (start && !busy)
                expected_results.push_back(filter_verdict(i_pair));
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [63:0] s;
        logic [63:0] d;
        int          pick;

        // Directed: extremes of both states
        queue_pair('0, '0);
        queue_pair('1, '0);
        queue_pair('0, '1);
        queue_pair('1, '1);
        // every byte with its top bit set, so the first doubling reduces
        queue_pair(64'h8080_8080_8080_8080, '0);
        queue_pair(64'h0101_0101_0101_0101, 64'hFEFE_FEFE_FEFE_FEFE);
        queue_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        // identical states: difference zero, filter passes
        s = random_state();
        queue_pair(s, s);
        // filter passes with low nibbles fully set, and with single bits
        queue_with_difference(random_state(), 64'h0F0F_0F0F_0F0F_0F0F);
        queue_with_difference(random_state(), 64'h0000_0000_0000_0001);
        queue_with_difference(random_state(), 64'h0800_0000_0000_0000);
        // near misses: one bit set in a high nibble
        queue_with_difference(random_state(), 64'h1000_0000_0000_0000);
        queue_with_difference(random_state(), 64'h0000_0000_0000_0080);
        queue_with_difference(random_state(), 64'h0F0F_0F0F_8F0F_0F0F);
        // one byte of the first state active, each position in both columns
        for (int i = 0; i < 8; i++)
            queue_pair(64'hFF << (8 * i), '0);

        // Random part: mostly pairs built to pass the filter or just miss it,
        // so both outcomes of the flag are well exercised.
        for (int n = 0; n < 800; n++) begin
            pick = $urandom_range(99, 0);
            s    = random_state();
            d    = random_state() & ~HIGH_NIB_MASK;
            if (pick < 40) begin
                queue_with_difference(s, d);
            end else if (pick < 55) begin
                d[4 + 8 * $urandom_range(7, 0) + $urandom_range(3, 0)] = 1'b1;
                queue_with_difference(s, d);
            end else if (pick < 60) begin
                queue_pair(s, s);
            end else if (pick < 70) begin
                queue_pair(s, s ^ ({56'h0, 8'($urandom())} << (8 * $urandom_range(7, 0))));
            end else begin
                queue_pair(s, random_state());
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all words taken, then all results in, then a wait to catch strays
        while (pair_backlog.size() != 0 || start)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: fails the run if it outlasts a limit set at many times
    // the slowest correct run of ~820 words.
    initial begin : watchdog
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
